### rtl/boost_vote_aggregator_defines.svh
`ifndef BOOST_VOTE_AGGREGATOR_DEFINES_SVH
`define BOOST_VOTE_AGGREGATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BVA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bva_pkg.sv
package bva_pkg;

    localparam int NUM_GROUPS     = 4;
    localparam int NUM_REQUESTERS = 8;

    localparam int REQ_W  = 3;
    localparam int GRP_W  = 3;
    localparam int VOTE_W = 14;
    localparam int QUO_W  = 4;
    localparam int REM_W  = 11;
    localparam int SUM_W  = 15;

    localparam int DEPTH   = NUM_GROUPS * NUM_REQUESTERS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;

    localparam int PRIO_LO   = 100;
    localparam int PRIO_HI   = 1100;
    localparam int DIVISOR   = 1000;
    localparam int BOOST_MIN = -100;
    localparam int BOOST_MAX = 5000;
    localparam int REM_INIT  = -101;
    localparam int MAX_QUO   = 8;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    function automatic logic [QUO_W-1:0] quo_of(input logic [VOTE_W-1:0] mag);
        logic [QUO_W-1:0] q;
        q = '0;
        for (int k = 1; k <= MAX_QUO; k++) begin
            if (mag >= VOTE_W'(k * DIVISOR)) begin
                q = QUO_W'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [VOTE_W-1:0] times_div(input logic [QUO_W-1:0] q);
        logic [VOTE_W-1:0] p;
        p = '0;
        for (int k = 1; k <= MAX_QUO; k++) begin
            if (q == QUO_W'(k)) begin
                p = VOTE_W'(k * DIVISOR);
            end
        end
        return p;
    endfunction

endpackage

### rtl/bva_vote_mem.sv
module bva_vote_mem (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [bva_pkg::ADDR_W-1:0]          wr_addr,
    input  logic signed [bva_pkg::VOTE_W-1:0]   wr_data,
    input  logic [bva_pkg::ADDR_W-1:0]          rd_addr,
    output logic signed [bva_pkg::VOTE_W-1:0]   rd_data
);

    logic signed [bva_pkg::VOTE_W-1:0] mem [bva_pkg::DEPTH];
    logic [bva_pkg::DEPTH-1:0]         valid_reg;
    logic signed [bva_pkg::VOTE_W-1:0] rd_data_reg;
    logic                              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr] && !(wr_en && wr_addr == rd_addr);
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/bva_scan_unit.sv
module bva_scan_unit (
    input  logic                                aclk,
    input  bva_pkg::scan_ctl_t                  ctl,
    input  logic signed [bva_pkg::VOTE_W-1:0]   vote,
    output logic signed [bva_pkg::VOTE_W-1:0]   level
);

    logic signed [bva_pkg::VOTE_W-1:0] prio_reg, prio_next;
    logic                              prio_set_reg, prio_set_next;
    logic [bva_pkg::QUO_W-1:0]         thou_reg, thou_next;
    logic signed [bva_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                              any_reg, any_next;

    logic                              neg;
    logic [bva_pkg::VOTE_W-1:0]        mag;
    logic [bva_pkg::QUO_W-1:0]         quo;
    logic [bva_pkg::REM_W-2:0]         rem_u;
    logic signed [bva_pkg::REM_W-1:0]  rem_s;
    logic                              is_prio;
    logic signed [bva_pkg::SUM_W-1:0]  sum;
    logic signed [bva_pkg::SUM_W-1:0]  pre;

    always_comb begin
        neg     = vote[bva_pkg::VOTE_W-1];
        mag     = neg ? bva_pkg::VOTE_W'(-vote) : bva_pkg::VOTE_W'(vote);
        quo     = bva_pkg::quo_of(mag);
        rem_u   = (bva_pkg::REM_W-1)'(mag - bva_pkg::times_div(quo));
        rem_s   = neg ? -$signed({1'b0, rem_u}) : $signed({1'b0, rem_u});
        is_prio = (vote == bva_pkg::VOTE_W'(bva_pkg::PRIO_LO))
               || (vote == bva_pkg::VOTE_W'(bva_pkg::PRIO_HI));

        prio_next     = prio_reg;
        prio_set_next = prio_set_reg;
        thou_next     = thou_reg;
        rem_next      = rem_reg;
        any_next      = any_reg;
        if (ctl.clear) begin
            prio_next     = '0;
            prio_set_next = 1'b0;
            thou_next     = '0;
            rem_next      = bva_pkg::REM_W'(bva_pkg::REM_INIT);
            any_next      = 1'b0;
        end else if (ctl.step && vote != '0) begin
            if (is_prio) begin
                prio_set_next = 1'b1;
                if (vote > prio_reg) begin
                    prio_next = vote;
                end
            end
            if (!neg && quo > thou_reg) begin
                thou_next = quo;
            end
            if (rem_s > rem_reg) begin
                rem_next = rem_s;
            end
            any_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg     <= prio_next;
        prio_set_reg <= prio_set_next;
        thou_reg     <= thou_next;
        rem_reg      <= rem_next;
        any_reg      <= any_next;
    end

    always_comb begin
        sum = $signed({1'b0, bva_pkg::times_div(thou_reg)})
            + {{(bva_pkg::SUM_W-bva_pkg::REM_W){rem_reg[bva_pkg::REM_W-1]}}, rem_reg};
        if (prio_set_reg) begin
            pre = {prio_reg[bva_pkg::VOTE_W-1], prio_reg};
        end else if (any_reg) begin
            pre = sum;
        end else begin
            pre = '0;
        end
        if (pre < bva_pkg::SUM_W'(bva_pkg::BOOST_MIN)) begin
            level = bva_pkg::VOTE_W'(bva_pkg::BOOST_MIN);
        end else if (pre > bva_pkg::SUM_W'(bva_pkg::BOOST_MAX)) begin
            level = bva_pkg::VOTE_W'(bva_pkg::BOOST_MAX);
        end else begin
            level = pre[bva_pkg::VOTE_W-1:0];
        end
    end

endmodule

### rtl/boost_vote_aggregator.sv
// A valid group's request runs through SCAN, DRAIN and FINISH to HOLD; a bad group
// goes straight to HOLD. A new request is taken only in IDLE, after the result is accepted.
// One vote memory read per cycle over the group's row sets the scan length
// (NUM_REQUESTERS reads, one drain, one finish).
// Reset (aresetn low, synchronous) clears the vote valid bits, the override
// register and the sequencer; unwritten votes read as zero.
`include "boost_vote_aggregator_defines.svh"

module boost_vote_aggregator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // requester[2:0], group[5:3], vote[19:6], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // boost_level[13:0], zero pad
    output logic [1:0]  m_tuser    // group_error[0], apply_now[1]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_HOLD
    } state_t;

    state_t                              state_reg;
    logic                                override_reg;
    logic [bva_pkg::GRP_W-1:0]           grp_reg;
    logic [bva_pkg::IDX_W-1:0]           cnt_reg;
    logic                                rd_pend_reg;
    logic signed [bva_pkg::VOTE_W-1:0]   level_reg;
    logic                                err_reg;
    logic                                apply_reg;

    logic [bva_pkg::REQ_W-1:0]           in_req;
    logic [bva_pkg::GRP_W-1:0]           in_grp;
    logic signed [bva_pkg::VOTE_W-1:0]   in_vote;
    logic                                accept;
    logic                                grp_ok;
    logic                                req_ok;
    logic                                wr_en;
    logic [bva_pkg::ADDR_W-1:0]          wr_addr;
    logic [bva_pkg::ADDR_W-1:0]          rd_addr;
    logic signed [bva_pkg::VOTE_W-1:0]   rd_data;
    logic signed [bva_pkg::VOTE_W-1:0]   scan_level;
    bva_pkg::scan_ctl_t                  scan_ctl;

    assign in_req  = s_tdata[2:0];
    assign in_grp  = s_tdata[5:3];
    assign in_vote = $signed(s_tdata[19:6]);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign grp_ok   = {1'b0, in_grp} < (bva_pkg::GRP_W+1)'(bva_pkg::NUM_GROUPS);
    assign req_ok   = {1'b0, in_req} < (bva_pkg::REQ_W+1)'(bva_pkg::NUM_REQUESTERS);
    assign wr_en    = accept && grp_ok && req_ok;
    assign wr_addr  = bva_pkg::ADDR_W'(in_grp) * bva_pkg::ADDR_W'(bva_pkg::NUM_REQUESTERS)
                    + bva_pkg::ADDR_W'(in_req);
    assign rd_addr  = bva_pkg::ADDR_W'(grp_reg) * bva_pkg::ADDR_W'(bva_pkg::NUM_REQUESTERS)
                    + bva_pkg::ADDR_W'(cnt_reg);

    assign scan_ctl.clear = accept;
    assign scan_ctl.step  = rd_pend_reg;

    bva_vote_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_vote),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bva_scan_unit u_scan (
        .aclk  (aclk),
        .ctl   (scan_ctl),
        .vote  (rd_data),
        .level (scan_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            override_reg <= 1'b0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                override_reg <= cfg_wdata;
            end
            rd_pend_reg <= (state_reg == ST_SCAN);
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        grp_reg <= in_grp;
                        cnt_reg <= '0;
                        if (grp_ok) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            level_reg <= '0;
                            err_reg   <= 1'b1;
                            apply_reg <= 1'b0;
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg == bva_pkg::IDX_W'(bva_pkg::NUM_REQUESTERS - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    level_reg <= scan_level;
                    err_reg   <= 1'b0;
                    apply_reg <= !override_reg;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_HOLD);
    assign m_tdata  = {{(16 - bva_pkg::VOTE_W){1'b0}}, level_reg};
    assign m_tuser  = {apply_reg, err_reg};

    `BVA_ASSERT_NEXT(a_bad_group_result, aclk, aresetn, accept && !grp_ok, m_tvalid && err_reg && !apply_reg && level_reg == '0, "bad group request did not yield an error result")
    `BVA_ASSERT_NOW(a_error_no_apply, aclk, aresetn, m_tvalid && err_reg, !apply_reg, "apply raised on an error result")
    `BVA_ASSERT_NOW(a_scan_ctl_exclusive, aclk, aresetn, scan_ctl.clear, !scan_ctl.step, "scan cleared while a vote is still in flight")
    `BVA_ASSERT_NEXT(a_finish_to_hold, aclk, aresetn, state_reg == ST_FINISH, m_tvalid && !err_reg, "finished scan did not present a result")

endmodule
